// ===== hw/rtl/ber_tlv_stream_parser_top_defines.svh =====
// Assertion macros used by the BER-TLV stream parser checker.
`ifndef BER_TLV_STREAM_PARSER_TOP_DEFINES_SVH
`define BER_TLV_STREAM_PARSER_TOP_DEFINES_SVH

// Clocked on clk, disabled while rst_n is low, generic failure message.
`define BTLV_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("btlv check failed");

// Same, with a caller-supplied message.
`define BTLV_ASSERT_MSG(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== hw/rtl/btlv_pkg.sv =====
// Types and constants shared by the BER-TLV stream parser modules.
package btlv_pkg;

    localparam int TAG_BITS      = 32;
    localparam int LEN_BITS      = 16;
    localparam int DEPTH_BITS    = 4;
    localparam int MAX_LEN_BYTES = 2;
    localparam int OUTQ_DEPTH    = 2;

    localparam logic [7:0] CONS_MASK      = 8'h20;
    localparam logic [7:0] TAG_CONT_MASK  = 8'h1F;
    localparam logic [7:0] LEN_LONG_MASK  = 8'h80;
    localparam logic [7:0] LEN_COUNT_MASK = 8'h7F;

    typedef enum logic [2:0] {
        PH_TAG_FIRST = 3'd0,
        PH_TAG_MORE  = 3'd1,
        PH_LEN_FIRST = 3'd2,
        PH_LEN_MORE  = 3'd3,
        PH_VALUE     = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_VALUE  = 2'd1,
        EV_ERROR  = 2'd2
    } ev_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_TAG_LONG = 3'd1,
        ERR_LEN_LONG = 3'd2,
        ERR_TOO_DEEP = 3'd3,
        ERR_OVERRUN  = 3'd4
    } err_code_t;

    typedef struct packed {
        ev_kind_t                kind;
        logic [TAG_BITS-1:0]     tag;
        logic [LEN_BITS-1:0]     len;
        logic                    cons;
        logic [DEPTH_BITS-1:0]   depth;
        logic [7:0]              pbyte;
        logic                    plast;
        err_code_t               code;
    } event_t;

    typedef struct packed {
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
    } push_t;

endpackage

// ===== hw/rtl/btlv_parse.sv =====
// Input register and per-byte TLV parsing logic with level stack.
module btlv_parse #(
    parameter int MAX_DEPTH     = 8,
    parameter int MAX_TAG_BYTES = 4,
    parameter int POSITION_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic [1:0]      q_free,
    output btlv_pkg::push_t push
);
    import btlv_pkg::*;

    localparam int OW = $clog2(MAX_DEPTH + 1);
    localparam int TW = $clog2(MAX_TAG_BYTES + 1);
    localparam int EW = ((POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS) + 1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
    localparam logic [EW-1:0]            POS_MAX = EW'({POSITION_BITS{1'b1}});

    logic                     hold_valid_reg, hold_valid_next;
    logic [7:0]               hold_byte_reg;
    logic                     hold_last_reg;
    phase_t                   phase_reg, phase_next;
    logic [TAG_BITS-1:0]      tag_reg, tag_next;
    logic [TW-1:0]            tag_cnt_reg, tag_cnt_next;
    logic [LEN_BITS-1:0]      len_reg, len_next;
    logic [1:0]               len_left_reg, len_left_next;
    logic                     cons_reg, cons_next;
    logic [LEN_BITS-1:0]      value_left_reg, value_left_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [OW-1:0]            open_reg, open_next;
    logic                     skip_reg, skip_next;
    logic [POSITION_BITS-1:0] ends_reg [MAX_DEPTH];

    logic                     advance;
    logic                     hdr_done;
    logic                     hdr_ev;
    logic                     val_ev;
    logic                     val_last;
    logic                     push_lvl;
    logic                     trunc;
    err_code_t                err;
    logic [EW-1:0]            end_full;
    logic [POSITION_BITS-1:0] top_end;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] end_view;
    logic [OW-1:0]            open_push;
    logic [MAX_DEPTH-1:0]     keep_vec;
    logic [LEN_BITS-1:0]      value_dec;
    logic [1:0]               len_left_dec;
    logic [7:0]               len_count;
    logic [1:0]               need;
    event_t                   ev_a;
    event_t                   ev_b;
    logic                     has_a;

    always_comb
    begin
        top_end = '0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if (OW'(i + 1) == open_reg)
            begin
                top_end = ends_reg[i];
            end
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        tag_next        = tag_reg;
        tag_cnt_next    = tag_cnt_reg;
        len_next        = len_reg;
        len_left_next   = len_left_reg;
        cons_next       = cons_reg;
        value_left_next = value_left_reg;
        pos_next        = pos_reg;
        open_next       = open_reg;
        skip_next       = skip_reg;
        hdr_done        = 1'b0;
        hdr_ev          = 1'b0;
        val_ev          = 1'b0;
        val_last        = 1'b0;
        push_lvl        = 1'b0;
        trunc           = 1'b0;
        err             = ERR_NONE;
        end_full        = '0;
        open_push       = open_reg;
        keep_vec        = '0;
        end_view        = '0;
        value_dec       = '0;
        len_left_dec    = '0;
        len_count       = hold_byte_reg & LEN_COUNT_MASK;
        pos_inc         = pos_reg + POS_ONE;

        if (skip_reg)
        begin
            if (hold_last_reg)
            begin
                phase_next = PH_TAG_FIRST;
                pos_next   = '0;
                open_next  = '0;
                skip_next  = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TAG_FIRST:
                begin
                    tag_next     = TAG_BITS'(hold_byte_reg);
                    tag_cnt_next = TW'(1);
                    cons_next    = (hold_byte_reg & CONS_MASK) != 8'h00;
                    if ((hold_byte_reg & TAG_CONT_MASK) == TAG_CONT_MASK)
                    begin
                        if (MAX_TAG_BYTES <= 1)
                            err = ERR_TAG_LONG;
                        else
                            phase_next = PH_TAG_MORE;
                    end
                    else
                    begin
                        phase_next = PH_LEN_FIRST;
                    end
                end
                PH_TAG_MORE:
                begin
                    tag_next     = {tag_reg[TAG_BITS-9:0], hold_byte_reg};
                    tag_cnt_next = tag_cnt_reg + TW'(1);
                    if ((hold_byte_reg & LEN_LONG_MASK) != 8'h00)
                    begin
                        if (tag_cnt_next >= TW'(MAX_TAG_BYTES))
                            err = ERR_TAG_LONG;
                    end
                    else
                    begin
                        phase_next = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST:
                begin
                    if ((hold_byte_reg & LEN_LONG_MASK) == 8'h00)
                    begin
                        len_next = LEN_BITS'(hold_byte_reg);
                        hdr_done = 1'b1;
                    end
                    else if (len_count == 8'h00 || len_count > 8'(MAX_LEN_BYTES))
                    begin
                        err = ERR_LEN_LONG;
                    end
                    else
                    begin
                        len_left_next = len_count[1:0];
                        len_next      = '0;
                        phase_next    = PH_LEN_MORE;
                    end
                end
                PH_LEN_MORE:
                begin
                    len_next = {len_reg[LEN_BITS-9:0], hold_byte_reg};
                    if (len_left_reg != 2'd0)
                        len_left_dec = len_left_reg - 2'd1;
                    len_left_next = len_left_dec;
                    if (len_left_dec == 2'd0)
                        hdr_done = 1'b1;
                end
                PH_VALUE:
                begin
                    val_ev   = 1'b1;
                    val_last = value_left_reg <= LEN_BITS'(1);
                    if (value_left_reg != '0)
                        value_dec = value_left_reg - LEN_BITS'(1);
                    value_left_next = value_dec;
                    if (value_dec == '0)
                        phase_next = PH_TAG_FIRST;
                end
                default:
                begin
                    phase_next = PH_TAG_FIRST;
                end
            endcase

            if (hdr_done)
            begin
                end_full = EW'(pos_reg) + EW'(len_next) + EW'(1);
                if (cons_next && open_reg >= OW'(MAX_DEPTH))
                begin
                    err = ERR_TOO_DEEP;
                end
                else if (end_full > POS_MAX ||
                         (open_reg != '0 && end_full > EW'(top_end)))
                begin
                    err = ERR_OVERRUN;
                end
                else
                begin
                    hdr_ev = 1'b1;
                    if (cons_next)
                    begin
                        push_lvl   = 1'b1;
                        phase_next = PH_TAG_FIRST;
                    end
                    else if (len_next != '0)
                    begin
                        value_left_next = len_next;
                        phase_next      = PH_VALUE;
                    end
                    else
                    begin
                        phase_next = PH_TAG_FIRST;
                    end
                end
            end

            if (err != ERR_NONE)
            begin
                phase_next = PH_TAG_FIRST;
                pos_next   = '0;
                open_next  = '0;
                skip_next  = !hold_last_reg;
                push_lvl   = 1'b0;
            end
            else
            begin
                pos_next  = pos_inc;
                open_push = open_reg + OW'(push_lvl);
                for (int i = 0; i < MAX_DEPTH; i++)
                begin
                    end_view = (push_lvl && OW'(i) == open_reg) ?
                               end_full[POSITION_BITS-1:0] : ends_reg[i];
                    keep_vec[i] = (OW'(i) < open_push) && (end_view != pos_inc);
                end
                if (phase_next == PH_TAG_FIRST)
                begin
                    open_next = '0;
                    for (int i = 0; i < MAX_DEPTH; i++)
                    begin
                        if (keep_vec[i])
                            open_next = OW'(i + 1);
                    end
                end
                else
                    open_next = open_push;
                if (hold_last_reg)
                begin
                    trunc      = (phase_next != PH_TAG_FIRST) || (open_next != '0);
                    phase_next = PH_TAG_FIRST;
                    pos_next   = '0;
                    open_next  = '0;
                end
            end
        end
    end

    always_comb
    begin
        ev_a  = '0;
        ev_b  = '0;
        has_a = 1'b1;
        if (err != ERR_NONE)
        begin
            ev_a.kind = EV_ERROR;
            ev_a.code = err;
        end
        else if (hdr_ev)
        begin
            ev_a.kind  = EV_HEADER;
            ev_a.tag   = tag_next;
            ev_a.len   = len_next;
            ev_a.cons  = cons_next;
            ev_a.depth = DEPTH_BITS'(open_reg);
        end
        else if (val_ev)
        begin
            ev_a.kind  = EV_VALUE;
            ev_a.pbyte = hold_byte_reg;
            ev_a.plast = val_last;
        end
        else
        begin
            has_a = 1'b0;
        end

        ev_b.kind = EV_ERROR;
        ev_b.code = ERR_OVERRUN;

        need    = 2'(has_a) + 2'(trunc);
        advance = hold_valid_reg && (need <= q_free);

        push.count = advance ? need : 2'd0;
        push.ev0   = has_a ? ev_a : ev_b;
        push.ev1   = ev_b;
    end

    assign in_ready = !hold_valid_reg || advance;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= PH_TAG_FIRST;
            pos_reg        <= '0;
            open_reg       <= '0;
            skip_reg       <= 1'b0;
            tag_cnt_reg    <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            if (advance)
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                open_reg    <= open_next;
                skip_reg    <= skip_next;
                tag_cnt_reg <= tag_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= in_last;
        end
        if (advance)
        begin
            tag_reg        <= tag_next;
            len_reg        <= len_next;
            len_left_reg   <= len_left_next;
            cons_reg       <= cons_next;
            value_left_reg <= value_left_next;
            for (int i = 0; i < MAX_DEPTH; i++)
            begin
                if (push_lvl && OW'(i) == open_reg)
                    ends_reg[i] <= end_full[POSITION_BITS-1:0];
            end
        end
    end

endmodule

// ===== hw/rtl/btlv_outq.sv =====
// Two-entry result queue that registers parser events toward the output beat.
module btlv_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  btlv_pkg::push_t  push,
    output logic [1:0]       free,
    output btlv_pkg::event_t head,
    output logic             head_valid,
    input  logic             head_ready
);
    import btlv_pkg::*;

    event_t     slot0_reg, slot0_next;
    event_t     slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] cnt_pop;
    logic       pop;
    event_t     base0;

    assign pop        = (cnt_reg != 2'd0) && head_ready;
    assign head       = slot0_reg;
    assign head_valid = cnt_reg != 2'd0;
    assign free       = 2'(OUTQ_DEPTH) - cnt_reg;

    always_comb
    begin
        cnt_pop    = cnt_reg - 2'(pop);
        base0      = pop ? slot1_reg : slot0_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (cnt_pop)
            2'd0:
            begin
                slot0_next = push.ev0;
                slot1_next = push.ev1;
            end
            2'd1:
            begin
                slot0_next = base0;
                slot1_next = push.ev0;
            end
            default:
            begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        cnt_next = cnt_pop + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== hw/rtl/ber_tlv_stream_parser_top.sv =====
// Top level of the BER-TLV stream parser: input register, parser, result queue.
// A byte is captured in the input register, parsed, and its result beats are registered in the queue.
// Throughput: 1 byte per cycle for bytes with at most one result while the queue has room; a
// two-result byte waits for an empty queue and the next result byte waits for a popped beat.
// Reset: rst_n clears the frame state; the level end stack is written before read.
module ber_tlv_stream_parser_top #(
    parameter int MAX_DEPTH     = 8,
    parameter int MAX_TAG_BYTES = 4,
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // tag_value, element_length, is_constructed,
                                        // nest_depth, payload_byte, error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    output logic        m_axis_tlast
);
    import btlv_pkg::*;

    push_t      push;
    logic [1:0] q_free;
    event_t     head;

    btlv_parse #(
        .MAX_DEPTH     (MAX_DEPTH),
        .MAX_TAG_BYTES (MAX_TAG_BYTES),
        .POSITION_BITS (POSITION_BITS)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_free   (q_free),
        .push     (push)
    );

    btlv_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free       (q_free),
        .head       (head),
        .head_valid (m_axis_tvalid),
        .head_ready (m_axis_tready)
    );

    assign m_axis_tdata = {head.code, head.pbyte, head.depth, head.cons, head.len, head.tag};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.plast;

endmodule

// ===== hw/rtl/btlv_checker.sv =====
// Port-level checks on the parser output stream, bound to the top level.
`include "ber_tlv_stream_parser_top_defines.svh"

module btlv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import btlv_pkg::*;

    `BTLV_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    `BTLV_ASSERT_MSG(a_header_shape, m_axis_tvalid && m_axis_tuser == EV_HEADER |-> m_axis_tdata[63:53] == 11'd0 && !m_axis_tlast, "header beat carries value or error bits")
    `BTLV_ASSERT_MSG(a_error_shape, m_axis_tvalid && m_axis_tuser == EV_ERROR |-> m_axis_tdata[63:61] != 3'd0 && m_axis_tdata[60:0] == 61'd0 && !m_axis_tlast, "malformed error beat")
    `BTLV_ASSERT(a_last_on_value, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == EV_VALUE)

endmodule

bind ber_tlv_stream_parser_top btlv_checker u_btlv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
